// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the task queue RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante, outside reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante, outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/mpq_pkg.sv -----
// ----------------------------------------------------------------------------
// mpq_pkg
// Types and constants shared by the task queue modules.
// ----------------------------------------------------------------------------
package mpq_pkg;

    localparam int CAPACITY = 16;
    localparam int ID_BITS  = 8;
    localparam int PRIO_W   = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int COUNT_W  = $clog2(CAPACITY + 1);

    // Operation codes
    localparam logic [1:0] MODE_ADD  = 2'd0;
    localparam logic [1:0] MODE_DEL  = 2'd1;
    localparam logic [1:0] MODE_TAKE = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_MISS = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]                mode;
        logic [ID_BITS-1:0]        task_id;
        logic signed [PRIO_W-1:0]  priority_req;
    } req_t;

    typedef struct packed {
        logic [1:0]                status;
        logic [ID_BITS-1:0]        taken_id;
        logic signed [PRIO_W-1:0]  taken_priority;
        logic [COUNT_W-1:0]        waiting_count;
    } rsp_t;

    typedef struct packed {
        logic [ID_BITS-1:0]        id;
        logic signed [PRIO_W-1:0]  prio;
    } entry_t;

    // Running result of a table scan
    typedef struct packed {
        logic                      found;
        logic [IDX_W-1:0]          idx;
        entry_t                    entry;
    } best_t;

endpackage

// ----- src/mpq_table.sv -----
// ----------------------------------------------------------------------------
// mpq_table
// Task table storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mpq_table (
    input  logic                       clk,
    input  logic                       we,
    input  logic [mpq_pkg::IDX_W-1:0]  wr_addr,
    input  mpq_pkg::entry_t            wr_data,
    input  logic [mpq_pkg::IDX_W-1:0]  rd_addr,
    output mpq_pkg::entry_t            rd_data
);
    import mpq_pkg::*;

    entry_t mem [CAPACITY];

    // Write entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register read data
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- src/mpq_scan.sv -----
// ----------------------------------------------------------------------------
// mpq_scan
// Shared compare unit: tracks first id match or earliest minimum priority.
// ----------------------------------------------------------------------------
module mpq_scan (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        clr,
    input  logic                        vld,
    input  logic                        take,
    input  logic [mpq_pkg::ID_BITS-1:0] key_id,
    input  logic [mpq_pkg::IDX_W-1:0]   idx,
    input  mpq_pkg::entry_t             entry,
    output mpq_pkg::best_t              best
);
    import mpq_pkg::*;

    best_t best_reg;
    best_t best_next;
    logic  hit;

    // Strict less-than keeps the earliest entry among equal priorities
    always_comb
    begin
        if (take)
        begin
            hit = !best_reg.found ||
                  ($signed(entry.prio) < $signed(best_reg.entry.prio));
        end
        else
        begin
            hit = !best_reg.found && (entry.id == key_id);
        end
    end

    always_comb
    begin
        best_next = best_reg;
        if (clr)
        begin
            best_next.found = 1'b0;
        end
        else if (vld && hit)
        begin
            best_next.found = 1'b1;
            best_next.idx   = idx;
            best_next.entry = entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= '0;
        end
        else
        begin
            best_reg <= best_next;
        end
    end

    assign best = best_reg;

endmodule

// ----- src/min_priority_task_queue_top.sv -----
// ----------------------------------------------------------------------------
// min_priority_task_queue_top
// Ordered task table with add, delete by id and take lowest priority.
// ----------------------------------------------------------------------------
// A request transfers when start is high and busy is low; its single result
// appears on rsp with done high for one cycle and cannot be held off. Add, an
// unknown mode, and delete or take on an empty table return their result in
// the cycle after the transfer. Delete and take on a table of N entries first
// scan all N entries through the single table read port and compare unit, then
// close the gap by moving each later entry down one slot (no move when the hit
// is the last entry), and then return the result. A miss on delete skips the
// move. Worst case is a full table of 16 with a hit at position 0, set by the
// one-entry-per-cycle port.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module min_priority_task_queue_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  mpq_pkg::req_t   req,
    output logic            done,
    output mpq_pkg::rsp_t   rsp
);
    import mpq_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_SHIFT = 3'b100
    } state_t;

    state_t              state_reg,  state_next;
    req_t                req_reg,    req_next;
    rsp_t                rsp_reg,    rsp_next;
    logic                done_reg,   done_next;
    logic [COUNT_W-1:0]  count_reg,  count_next;
    logic [COUNT_W-1:0]  ptr_reg,    ptr_next;
    logic                rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]    rd_idx_reg, rd_idx_next;

    logic                mem_we;
    logic [IDX_W-1:0]    wr_addr;
    entry_t              wr_data;
    entry_t              rd_data;
    logic                scan_clr;
    logic                is_take;
    best_t               best;

    mpq_table u_table (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (ptr_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    assign is_take = (req_reg.mode == MODE_TAKE);

    mpq_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .clr    (scan_clr),
        .vld    (rd_vld_reg && (state_reg == ST_SCAN)),
        .take   (is_take),
        .key_id (req_reg.task_id),
        .idx    (rd_idx_reg),
        .entry  (rd_data),
        .best   (best)
    );

    // Sequence one operation
    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        rsp_next    = rsp_reg;
        done_next   = 1'b0;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        rd_vld_next = 1'b0;
        rd_idx_next = rd_idx_reg;
        mem_we      = 1'b0;
        wr_addr     = count_reg[IDX_W-1:0];
        wr_data     = '{id: req.task_id, prio: req.priority_req};
        scan_clr    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next                = req;
                    rsp_next.taken_id       = '0;
                    rsp_next.taken_priority = '0;
                    rsp_next.waiting_count  = count_reg;
                    if (req.mode == MODE_ADD)
                    begin
                        done_next = 1'b1;
                        if (count_reg == COUNT_W'(CAPACITY))
                        begin
                            rsp_next.status = STAT_FULL;
                        end
                        else
                        begin
                            mem_we                 = 1'b1;
                            count_next             = count_reg + 1'b1;
                            rsp_next.status        = STAT_OK;
                            rsp_next.waiting_count = count_reg + 1'b1;
                        end
                    end
                    else if (((req.mode == MODE_DEL) || (req.mode == MODE_TAKE)) &&
                             (count_reg != '0))
                    begin
                        state_next = ST_SCAN;
                        ptr_next   = '0;
                        scan_clr   = 1'b1;
                    end
                    else
                    begin
                        done_next       = 1'b1;
                        rsp_next.status = STAT_MISS;
                    end
                end
            end

            ST_SCAN:
            begin
                if (ptr_reg < count_reg)
                begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = ptr_reg[IDX_W-1:0];
                    ptr_next    = ptr_reg + 1'b1;
                end
                else if (!rd_vld_reg)
                begin
                    if (!best.found)
                    begin
                        done_next       = 1'b1;
                        rsp_next.status = STAT_MISS;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        ptr_next   = {1'b0, best.idx} + 1'b1;
                        state_next = ST_SHIFT;
                    end
                end
            end

            ST_SHIFT:
            begin
                // Move each later entry down one slot
                if (rd_vld_reg)
                begin
                    mem_we  = 1'b1;
                    wr_addr = rd_idx_reg - 1'b1;
                    wr_data = rd_data;
                end
                if (ptr_reg < count_reg)
                begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = ptr_reg[IDX_W-1:0];
                    ptr_next    = ptr_reg + 1'b1;
                end
                else if (!rd_vld_reg)
                begin
                    count_next             = count_reg - 1'b1;
                    done_next              = 1'b1;
                    rsp_next.status        = STAT_OK;
                    rsp_next.waiting_count = count_reg - 1'b1;
                    if (is_take)
                    begin
                        rsp_next.taken_id       = best.entry.id;
                        rsp_next.taken_priority = best.entry.prio;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            done_reg   <= 1'b0;
            count_reg  <= '0;
            ptr_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            count_reg  <= count_next;
            ptr_reg    <= ptr_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        rsp_reg    <= rsp_next;
        rd_idx_reg <= rd_idx_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // Checks
    `ASSERT_SAME(a_count_cap, clk, rst_n, 1'b1, count_reg <= COUNT_W'(CAPACITY), "count over capacity")
    `ASSERT_SAME(a_count_match, clk, rst_n, done_reg, rsp_reg.waiting_count == count_reg, "stale waiting count")
    `ASSERT_SAME(a_full_count, clk, rst_n, done_reg && (rsp_reg.status == STAT_FULL), count_reg == COUNT_W'(CAPACITY), "full status on non-full table")
    `ASSERT_NEXT(a_done_idle, clk, rst_n, (state_reg == ST_SHIFT) && done_next, !busy, "busy after result")

endmodule
